[rtl/kf3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf3_pkg
// Types, constants and fixed-point helpers shared by the Kalman filter block.
// ----------------------------------------------------------------------------
package kf3_pkg;

	localparam int WORD_W    = 32;
	localparam int FRAC_W    = 24;
	localparam int PROD_W    = 2 * WORD_W;
	localparam int NOISE_W   = 31;
	localparam int ADDR_W    = 6;
	localparam int MEM_DEPTH = 47;
	localparam int CFG_IDX_W = 3;
	localparam int CIDX_W    = 4;
	localparam int DIV_STEPS = WORD_W + FRAC_W;
	localparam int DCNT_W    = 6;

	typedef logic signed [WORD_W-1:0] word_t;

	localparam word_t W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t W_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam word_t W_ONE = word_t'(64'd1 << FRAC_W);

	// scratch memory map
	localparam logic [ADDR_W-1:0] A_EST   = 6'd0;
	localparam logic [ADDR_W-1:0] A_PRED  = 6'd3;
	localparam logic [ADDR_W-1:0] A_ECOV  = 6'd6;
	localparam logic [ADDR_W-1:0] A_PCOV  = 6'd15;
	localparam logic [ADDR_W-1:0] A_NOISE = 6'd24;
	localparam logic [ADDR_W-1:0] A_CTRL  = 6'd30;
	localparam logic [ADDR_W-1:0] A_MT    = 6'd33;
	localparam logic [ADDR_W-1:0] A_GAIN  = 6'd42;
	localparam logic [ADDR_W-1:0] A_ERR   = 6'd45;
	localparam logic [ADDR_W-1:0] A_SVAR  = 6'd46;

	localparam logic [CIDX_W-1:0] COEF_CNT = 4'd9;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_T01  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_T02  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_T12  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_T22  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_R    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_INIT = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_CEN  = 3'd6;

	typedef enum logic [1:0] {
		ACT_PREDICT = 2'd0,
		ACT_UPDATE  = 2'd1,
		ACT_LOAD    = 2'd2,
		ACT_RESET   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INV_VAR = 2'd1,
		ST_SAT     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		K_MAC  = 2'd0,
		K_ADD  = 2'd1,
		K_SUBF = 2'd2,
		K_DIV  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		AS_MEM  = 3'd0,
		AS_AMAT = 3'd1,
		AS_R    = 3'd2,
		AS_Z    = 3'd3,
		AS_INIT = 3'd4,
		AS_ZERO = 3'd5,
		AS_COEF = 3'd6
	} asel_t;

	typedef struct packed {
		logic              vld;
		kind_t             kind;
		asel_t             asel;
		logic [3:0]        aidx;
		logic [ADDR_W-1:0] aaddr;
		logic [ADDR_W-1:0] baddr;
		logic [ADDR_W-1:0] dst;
		logic              first;
		logic              wr;
		logic              dst_coef;
	} uop_t;

	typedef struct packed {
		logic start;
		logic load_out;
		logic show_pred;
		logic inv_var;
	} cmd_t;

	typedef struct packed {
		logic busy;
		logic acc_nonpos;
		logic ctrl_en;
	} stat_t;

	typedef struct packed {
		logic  ovf;
		word_t val;
	} sat_t;

	function automatic sat_t sat_clip(input logic signed [WORD_W:0] v);
		sat_t r;
		r.ovf = (v[WORD_W] != v[WORD_W-1]);
		r.val = r.ovf ? (v[WORD_W] ? W_MIN : W_MAX) : word_t'(v[WORD_W-1:0]);
		return r;
	endfunction

	function automatic sat_t sat_add(input word_t a, input word_t b);
		return sat_clip({a[WORD_W-1], a} + {b[WORD_W-1], b});
	endfunction

	function automatic sat_t sat_sub(input word_t a, input word_t b);
		return sat_clip({a[WORD_W-1], a} - {b[WORD_W-1], b});
	endfunction

	// drop fraction bits toward zero, then saturate to the word
	function automatic sat_t fx_trunc(input logic signed [PROD_W-1:0] p);
		logic signed [PROD_W-1:0] bias;
		logic signed [PROD_W-1:0] sh;
		sat_t r;
		bias = '0;
		if (p[PROD_W-1]) begin
			bias[FRAC_W-1:0] = '1;
		end
		sh = (p + bias) >>> FRAC_W;
		r.ovf = !((&sh[PROD_W-1:WORD_W-1]) || !(|sh[PROD_W-1:WORD_W-1]));
		r.val = r.ovf ? (p[PROD_W-1] ? W_MIN : W_MAX) : word_t'(sh[WORD_W-1:0]);
		return r;
	endfunction

	function automatic word_t amat_entry(input logic [3:0] idx, input word_t t01,
		input word_t t02, input word_t t12, input word_t t22);
		word_t r;
		unique case (idx)
			4'd0, 4'd4: r = W_ONE;
			4'd1:       r = t01;
			4'd2:       r = t02;
			4'd5:       r = t12;
			4'd8:       r = t22;
			default:    r = '0;
		endcase
		return r;
	endfunction

endpackage

[rtl/kf3_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf3_div
// Restoring fixed-point divider, one quotient bit per cycle, saturating.
// ----------------------------------------------------------------------------
module kf3_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  kf3_pkg::word_t  num,
	input  kf3_pkg::word_t  den,
	output logic            busy,
	output logic            done,
	output kf3_pkg::word_t  quo,
	output logic            ovf
);

	localparam int W = kf3_pkg::WORD_W;

	logic                        busy_q;
	logic                        done_q;
	logic [kf3_pkg::DCNT_W-1:0]  cnt_q;
	logic                        neg_q;
	logic                        ovf_q;
	logic [W-1:0]                un_q;
	logic [W-1:0]                r_q;
	logic [W-1:0]                q_q;
	logic [W-1:0]                d_q;

	logic [W-1:0] r2;
	logic [W-1:0] rn;
	logic         ge;
	logic [W:0]   q2;
	logic [W:0]   lim;
	logic         over;

	always_comb begin
		r2   = {r_q[W-2:0], un_q[W-1]};
		ge   = (r2 >= d_q);
		rn   = ge ? (r2 - d_q) : r2;
		q2   = {q_q, ge};
		lim  = neg_q ? ((W+1)'(1) << (W-1)) : (((W+1)'(1) << (W-1)) - (W+1)'(1));
		over = (q2 > lim);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= kf3_pkg::DCNT_W'(kf3_pkg::DIV_STEPS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[W-1];
			un_q  <= num[W-1] ? (W'(0) - W'(num)) : W'(num);
			d_q   <= W'(den);
			r_q   <= '0;
			q_q   <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q) begin
			un_q  <= {un_q[W-2:0], 1'b0};
			r_q   <= rn;
			q_q   <= over ? lim[W-1:0] : q2[W-1:0];
			ovf_q <= ovf_q | over;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign ovf  = ovf_q;
	assign quo  = neg_q ? kf3_pkg::word_t'(W'(0) - q_q) : kf3_pkg::word_t'(q_q);

endmodule

[rtl/kf3_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf3_dpath
// Scratch memory, multiply-accumulate pipeline, divider and output register.
// ----------------------------------------------------------------------------
module kf3_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  kf3_pkg::uop_t                      uop,
	input  kf3_pkg::cmd_t                      cmd,
	output kf3_pkg::stat_t                     stat,
	input  kf3_pkg::word_t                     in_meas,
	input  logic [kf3_pkg::CIDX_W-1:0]         in_cidx,
	input  kf3_pkg::word_t                     in_cval,
	input  logic                               cfg_wr_en,
	input  logic [kf3_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kf3_pkg::WORD_W-1:0]         cfg_data,
	output kf3_pkg::word_t                     out_pos,
	output kf3_pkg::word_t                     out_vel,
	output kf3_pkg::word_t                     out_acc,
	output kf3_pkg::status_t                   out_status
);

	localparam int AW = kf3_pkg::ADDR_W;

	// configuration
	kf3_pkg::word_t                  t01_q, t02_q, t12_q, t22_q;
	logic [kf3_pkg::NOISE_W-1:0]     rvar_q, init_q;
	logic                            cen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t01_q  <= 32'sd16777216;
			t02_q  <= 32'sd8388608;
			t12_q  <= 32'sd16777216;
			t22_q  <= 32'sd16777216;
			rvar_q <= 31'd167772;
			init_q <= 31'd167772;
			cen_q  <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				kf3_pkg::CFG_T01:  t01_q  <= kf3_pkg::word_t'(cfg_data);
				kf3_pkg::CFG_T02:  t02_q  <= kf3_pkg::word_t'(cfg_data);
				kf3_pkg::CFG_T12:  t12_q  <= kf3_pkg::word_t'(cfg_data);
				kf3_pkg::CFG_T22:  t22_q  <= kf3_pkg::word_t'(cfg_data);
				kf3_pkg::CFG_R:    rvar_q <= cfg_data[kf3_pkg::NOISE_W-1:0];
				kf3_pkg::CFG_INIT: init_q <= cfg_data[kf3_pkg::NOISE_W-1:0];
				kf3_pkg::CFG_CEN:  cen_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// item operands, held for the whole step
	kf3_pkg::word_t                z_q, cval_q;
	logic [kf3_pkg::CIDX_W-1:0]    cidx_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			z_q    <= in_meas;
			cval_q <= in_cval;
			cidx_q <= in_cidx;
		end
	end

	// scratch memory with per-entry valid bits (unwritten entries read zero)
	kf3_pkg::word_t                mem_q [kf3_pkg::MEM_DEPTH];
	logic [kf3_pkg::MEM_DEPTH-1:0] valid_q;

	logic           wr_en;
	logic [AW-1:0]  wr_addr;
	kf3_pkg::word_t wr_data;

	kf3_pkg::uop_t  uop_s1, uop_s2, uop_s3;
	logic           v_s1, v_s2, v_s3;
	kf3_pkg::word_t rda_s1, rdb_s1;
	kf3_pkg::word_t opa_s2, opa_s3;
	logic signed [kf3_pkg::PROD_W-1:0] prod_s2;
	kf3_pkg::sat_t  pq_s3;
	kf3_pkg::word_t acc_q;
	logic           sat_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rda_s1 <= valid_q[uop.aaddr] ? mem_q[uop.aaddr] : '0;
		rdb_s1 <= valid_q[uop.baddr] ? mem_q[uop.baddr] : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// operand select and multiply
	kf3_pkg::word_t opa;

	always_comb begin
		unique case (uop_s1.asel)
			kf3_pkg::AS_MEM:  opa = rda_s1;
			kf3_pkg::AS_AMAT: opa = kf3_pkg::amat_entry(uop_s1.aidx, t01_q, t02_q,
				t12_q, t22_q);
			kf3_pkg::AS_R:    opa = kf3_pkg::word_t'({1'b0, rvar_q});
			kf3_pkg::AS_Z:    opa = z_q;
			kf3_pkg::AS_INIT: opa = kf3_pkg::word_t'({1'b0, init_q});
			kf3_pkg::AS_COEF: opa = cval_q;
			default:          opa = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= uop.vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		uop_s1  <= uop;
		uop_s2  <= uop_s1;
		uop_s3  <= uop_s2;
		opa_s2  <= opa;
		prod_s2 <= kf3_pkg::PROD_W'(opa) * kf3_pkg::PROD_W'(rdb_s1);
		opa_s3  <= opa_s2;
		pq_s3   <= kf3_pkg::fx_trunc(prod_s2);
	end

	// divider for the gain column
	logic           div_busy, div_done, div_ovf;
	kf3_pkg::word_t div_quo;
	logic [AW-1:0]  div_dst_q;
	logic           div_start;

	assign div_start = v_s1 && (uop_s1.kind == kf3_pkg::K_DIV);

	always_ff @(posedge clk) begin
		if (div_start) begin
			div_dst_q <= uop_s1.dst;
		end
	end

	kf3_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (rda_s1),
		.den    (rdb_s1),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo),
		.ovf    (div_ovf)
	);

	// accumulate stage
	kf3_pkg::sat_t  res;
	logic           res_sat;
	logic [AW-1:0]  s3_dst;
	logic           s3_wr;

	always_comb begin
		res     = '0;
		res_sat = 1'b0;
		unique case (uop_s3.kind)
			kf3_pkg::K_MAC: begin
				if (uop_s3.first) begin
					res = pq_s3;
				end else begin
					res = kf3_pkg::sat_add(acc_q, pq_s3.val);
				end
				res_sat = pq_s3.ovf | res.ovf;
			end
			kf3_pkg::K_ADD: begin
				if (uop_s3.first) begin
					res.val = opa_s3;
				end else begin
					res = kf3_pkg::sat_add(acc_q, opa_s3);
				end
				res_sat = res.ovf;
			end
			kf3_pkg::K_SUBF: begin
				res     = kf3_pkg::sat_sub(opa_s3, acc_q);
				res_sat = res.ovf;
			end
			default: ;
		endcase
		if (uop_s3.dst_coef) begin
			s3_dst = kf3_pkg::A_NOISE + AW'(cidx_q);
			s3_wr  = uop_s3.wr && (cidx_q < kf3_pkg::COEF_CNT);
		end else begin
			s3_dst = uop_s3.dst;
			s3_wr  = uop_s3.wr;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = s3_dst;
		wr_data = res.val;
		if (div_done) begin
			wr_en   = 1'b1;
			wr_addr = div_dst_q;
			wr_data = div_quo;
		end else if (v_s3 && s3_wr) begin
			wr_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && uop_s3.kind != kf3_pkg::K_DIV) begin
			acc_q <= res.val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.start) begin
			sat_q <= 1'b0;
		end else if ((v_s3 && res_sat) || (div_done && div_ovf)) begin
			sat_q <= 1'b1;
		end
	end

	// copies of the two state vectors for the result
	kf3_pkg::word_t est_sh_q  [3];
	kf3_pkg::word_t pred_sh_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_sh_q  <= '{default: '0};
			pred_sh_q <= '{default: '0};
		end else if (wr_en) begin
			if (wr_addr < kf3_pkg::A_PRED) begin
				est_sh_q[wr_addr[1:0]] <= wr_data;
			end else if (wr_addr < kf3_pkg::A_ECOV) begin
				pred_sh_q[2'(wr_addr - kf3_pkg::A_PRED)] <= wr_data;
			end
		end
	end

	// output register
	kf3_pkg::word_t   opos_q, ovel_q, oacc_q;
	kf3_pkg::status_t ost_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			opos_q <= cmd.show_pred ? pred_sh_q[0] : est_sh_q[0];
			ovel_q <= cmd.show_pred ? pred_sh_q[1] : est_sh_q[1];
			oacc_q <= cmd.show_pred ? pred_sh_q[2] : est_sh_q[2];
			if (cmd.inv_var) begin
				ost_q <= kf3_pkg::ST_INV_VAR;
			end else if (sat_q) begin
				ost_q <= kf3_pkg::ST_SAT;
			end else begin
				ost_q <= kf3_pkg::ST_OK;
			end
		end
	end

	assign out_pos    = opos_q;
	assign out_vel    = ovel_q;
	assign out_acc    = oacc_q;
	assign out_status = ost_q;

	assign stat.busy       = v_s1 | v_s2 | v_s3 | div_busy | div_done;
	assign stat.acc_nonpos = acc_q[kf3_pkg::WORD_W-1] || (acc_q == '0);
	assign stat.ctrl_en    = cen_q;

endmodule

[rtl/kf3_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kf3_ctrl
// Step sequencer: walks the phases of each action and issues datapath ops.
// ----------------------------------------------------------------------------
module kf3_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [1:0]               s_action,
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output kf3_pkg::uop_t            uop,
	output kf3_pkg::cmd_t            cmd,
	input  kf3_pkg::stat_t           stat
);

	localparam int AW = kf3_pkg::ADDR_W;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_ISSUE = 4'b0010,
		S_WAIT  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	typedef enum logic [10:0] {
		PH_XS  = 11'b000_0000_0001,
		PH_M   = 11'b000_0000_0010,
		PH_PC  = 11'b000_0000_0100,
		PH_S   = 11'b000_0000_1000,
		PH_G   = 11'b000_0001_0000,
		PH_E   = 11'b000_0010_0000,
		PH_X   = 11'b000_0100_0000,
		PH_C   = 11'b000_1000_0000,
		PH_R   = 11'b001_0000_0000,
		PH_L   = 11'b010_0000_0000,
		PH_END = 11'b100_0000_0000
	} phase_t;

	state_t     state_q;
	phase_t     ph_q;
	logic [1:0] i_q, j_q, k_q;
	logic       chk_q, show_pred_q, inv_q, ovld_q;

	function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
		return 4'(r) * 4'd3 + 4'(c);
	endfunction

	function automatic logic [AW-1:0] qaddr(input logic [1:0] r, input logic [1:0] c);
		logic [AW-1:0] o;
		unique case ({r, c})
			4'b0000:          o = 6'd0;
			4'b0001, 4'b0100: o = 6'd1;
			4'b0010, 4'b1000: o = 6'd2;
			4'b0101:          o = 6'd3;
			4'b0110, 4'b1001: o = 6'd4;
			default:          o = 6'd5;
		endcase
		return kf3_pkg::A_NOISE + o;
	endfunction

	// op for the current position, loop limits and sequencing flags
	kf3_pkg::uop_t op;
	logic [1:0]    imax, jmax, kmax;
	logic          op_wait, op_chk;
	phase_t        ph_next;

	always_comb begin
		op         = '0;
		op.vld     = 1'b1;
		op.kind    = kf3_pkg::K_MAC;
		op.asel    = kf3_pkg::AS_MEM;
		imax       = 2'd0;
		jmax       = 2'd0;
		kmax       = 2'd0;
		op_wait    = 1'b0;
		op_chk     = 1'b0;
		ph_next    = PH_END;
		unique case (ph_q)
			PH_XS: begin
				imax     = 2'd2;
				kmax     = stat.ctrl_en ? 2'd3 : 2'd2;
				ph_next  = PH_M;
				op.first = (k_q == 2'd0);
				op.wr    = (k_q == kmax);
				op.dst   = kf3_pkg::A_PRED + AW'(i_q);
				if (k_q == 2'd3) begin
					op.aaddr = kf3_pkg::A_CTRL + AW'(i_q);
					op.baddr = kf3_pkg::A_EST + AW'(2);
				end else begin
					op.asel  = kf3_pkg::AS_AMAT;
					op.aidx  = idx3(i_q, k_q);
					op.baddr = kf3_pkg::A_EST + AW'(k_q);
				end
			end
			PH_M: begin
				imax     = 2'd2;
				jmax     = 2'd2;
				kmax     = 2'd2;
				ph_next  = PH_PC;
				op.asel  = kf3_pkg::AS_AMAT;
				op.aidx  = idx3(i_q, k_q);
				op.baddr = kf3_pkg::A_ECOV + AW'(idx3(k_q, j_q));
				op.first = (k_q == 2'd0);
				op.wr    = (k_q == 2'd2);
				op.dst   = kf3_pkg::A_MT + AW'(idx3(i_q, j_q));
			end
			PH_PC: begin
				imax    = 2'd2;
				jmax    = 2'd2;
				kmax    = 2'd3;
				op.dst  = kf3_pkg::A_PCOV + AW'(idx3(i_q, j_q));
				if (k_q == 2'd3) begin
					op.kind  = kf3_pkg::K_ADD;
					op.aaddr = qaddr(i_q, j_q);
					op.wr    = 1'b1;
				end else begin
					op.asel  = kf3_pkg::AS_AMAT;
					op.aidx  = idx3(j_q, k_q);
					op.baddr = kf3_pkg::A_MT + AW'(idx3(i_q, k_q));
					op.first = (k_q == 2'd0);
				end
			end
			PH_S: begin
				kmax    = 2'd1;
				ph_next = PH_G;
				op.kind = kf3_pkg::K_ADD;
				op.dst  = kf3_pkg::A_SVAR;
				if (k_q == 2'd0) begin
					op.aaddr = kf3_pkg::A_PCOV;
					op.first = 1'b1;
				end else begin
					op.asel = kf3_pkg::AS_R;
					op.wr   = 1'b1;
					op_wait = 1'b1;
					op_chk  = 1'b1;
				end
			end
			PH_G: begin
				imax     = 2'd2;
				ph_next  = PH_E;
				op.kind  = kf3_pkg::K_DIV;
				op.aaddr = kf3_pkg::A_PCOV + AW'(idx3(i_q, 2'd0));
				op.baddr = kf3_pkg::A_SVAR;
				op.dst   = kf3_pkg::A_GAIN + AW'(i_q);
				op_wait  = 1'b1;
			end
			PH_E: begin
				kmax    = 2'd1;
				ph_next = PH_X;
				op.dst  = kf3_pkg::A_ERR;
				if (k_q == 2'd0) begin
					op.kind  = kf3_pkg::K_ADD;
					op.aaddr = kf3_pkg::A_PRED;
					op.first = 1'b1;
				end else begin
					op.kind = kf3_pkg::K_SUBF;
					op.asel = kf3_pkg::AS_Z;
					op.wr   = 1'b1;
					op_wait = 1'b1;
				end
			end
			PH_X: begin
				imax    = 2'd2;
				kmax    = 2'd1;
				ph_next = PH_C;
				op.dst  = kf3_pkg::A_EST + AW'(i_q);
				if (k_q == 2'd0) begin
					op.aaddr = kf3_pkg::A_GAIN + AW'(i_q);
					op.baddr = kf3_pkg::A_ERR;
					op.first = 1'b1;
				end else begin
					op.kind  = kf3_pkg::K_ADD;
					op.aaddr = kf3_pkg::A_PRED + AW'(i_q);
					op.wr    = 1'b1;
				end
			end
			PH_C: begin
				imax   = 2'd2;
				jmax   = 2'd2;
				kmax   = 2'd1;
				op.dst = kf3_pkg::A_ECOV + AW'(idx3(i_q, j_q));
				if (k_q == 2'd0) begin
					op.aaddr = kf3_pkg::A_GAIN + AW'(i_q);
					op.baddr = kf3_pkg::A_PCOV + AW'(j_q);
					op.first = 1'b1;
				end else begin
					op.kind  = kf3_pkg::K_SUBF;
					op.aaddr = kf3_pkg::A_PCOV + AW'(idx3(i_q, j_q));
					op.wr    = 1'b1;
				end
			end
			PH_R: begin
				imax     = 2'd3;
				jmax     = 2'd2;
				op.kind  = kf3_pkg::K_ADD;
				op.first = 1'b1;
				op.wr    = 1'b1;
				op.asel  = kf3_pkg::AS_ZERO;
				if (i_q == 2'd0) begin
					op.dst = kf3_pkg::A_EST + AW'(j_q);
				end else begin
					op.dst = kf3_pkg::A_ECOV + AW'(idx3(2'(i_q - 2'd1), j_q));
					if (j_q == 2'(i_q - 2'd1)) begin
						op.asel = kf3_pkg::AS_INIT;
					end
				end
			end
			PH_L: begin
				op.kind     = kf3_pkg::K_ADD;
				op.asel     = kf3_pkg::AS_COEF;
				op.first    = 1'b1;
				op.wr       = 1'b1;
				op.dst_coef = 1'b1;
			end
			default: begin
				op.vld = 1'b0;
			end
		endcase
	end

	logic issue;
	logic out_free;
	logic load_out;

	assign issue    = (state_q == S_ISSUE) && (ph_q != PH_END);
	assign out_free = !ovld_q || m_tready;
	assign load_out = (state_q == S_DONE) && !stat.busy && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= PH_END;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			chk_q       <= 1'b0;
			show_pred_q <= 1'b0;
			inv_q       <= 1'b0;
			ovld_q      <= 1'b0;
		end else begin
			if (load_out) begin
				ovld_q <= 1'b1;
			end else if (ovld_q && m_tready) begin
				ovld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						i_q         <= '0;
						j_q         <= '0;
						k_q         <= '0;
						inv_q       <= 1'b0;
						show_pred_q <= (s_action == kf3_pkg::ACT_PREDICT);
						unique case (s_action)
							kf3_pkg::ACT_PREDICT: ph_q <= PH_XS;
							kf3_pkg::ACT_UPDATE:  ph_q <= PH_S;
							kf3_pkg::ACT_LOAD:    ph_q <= PH_L;
							default:              ph_q <= PH_R;
						endcase
						state_q <= S_ISSUE;
					end
				end
				S_ISSUE: begin
					if (ph_q == PH_END) begin
						state_q <= S_DONE;
					end else begin
						// advance k, then j, then i, then the phase
						if (k_q < kmax) begin
							k_q <= k_q + 2'd1;
						end else begin
							k_q <= '0;
							if (j_q < jmax) begin
								j_q <= j_q + 2'd1;
							end else begin
								j_q <= '0;
								if (i_q < imax) begin
									i_q <= i_q + 2'd1;
								end else begin
									i_q  <= '0;
									ph_q <= ph_next;
								end
							end
						end
						chk_q <= op_chk;
						if (op_wait) begin
							state_q <= S_WAIT;
						end
					end
				end
				S_WAIT: begin
					if (!stat.busy) begin
						chk_q   <= 1'b0;
						state_q <= S_ISSUE;
						// non-positive innovation variance: abandon the update
						if (chk_q && stat.acc_nonpos) begin
							inv_q <= 1'b1;
							ph_q  <= PH_END;
						end
					end
				end
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		uop           = op;
		uop.vld       = issue;
		cmd.start     = (state_q == S_IDLE) && s_tvalid;
		cmd.load_out  = load_out;
		cmd.show_pred = show_pred_q;
		cmd.inv_var   = inv_q;
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = ovld_q;

endmodule

[rtl/kalman_filter_3state_scalar_meas.sv]
`timescale 1ns / 1ps
// Predict issues one op per cycle into a three-stage multiply-accumulate pipeline; an
//   update holds for the variance check, for the innovation and for each of three
//   56-step divisions for the gain.
// Throughput: one item at a time; the next beat is taken once the previous result is
//   loaded. Reset clears state and coefficients and restores the register defaults.
// ----------------------------------------------------------------------------
// kalman_filter_3state_scalar_meas
// Three-state (position, velocity, acceleration) Kalman filter with one scalar
// position measurement, Q8.24 saturating arithmetic.
// ----------------------------------------------------------------------------
module kalman_filter_3state_scalar_meas (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [71:0]                       s_tdata,  // measurement[31:0], coef_index[35:32],
	                                                    // coef_value[67:36], zero pad
	input  logic [1:0]                        s_tuser,  // action[1:0]
	// result stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [95:0]                       m_tdata,  // out_pos[31:0], out_vel[63:32],
	                                                    // out_acc[95:64]
	output logic [1:0]                        m_tuser,  // status[1:0]
	// configuration writes
	input  logic                              cfg_wr_en,
	input  logic [kf3_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [kf3_pkg::WORD_W-1:0]        cfg_data
);

	kf3_pkg::uop_t    uop;
	kf3_pkg::cmd_t    cmd;
	kf3_pkg::stat_t   dp_stat;
	kf3_pkg::word_t   out_pos, out_vel, out_acc;
	kf3_pkg::status_t out_status;

	// sequencer: one op per cycle, holds on divides, on the variance check and on the innovation
	kf3_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_action (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.uop      (uop),
		.cmd      (cmd),
		.stat     (dp_stat)
	);

	// datapath: scratch memory, MAC pipeline, divider, result register
	kf3_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.uop        (uop),
		.cmd        (cmd),
		.stat       (dp_stat),
		.in_meas    (kf3_pkg::word_t'(s_tdata[31:0])),
		.in_cidx    (s_tdata[35:32]),
		.in_cval    (kf3_pkg::word_t'(s_tdata[67:36])),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_pos    (out_pos),
		.out_vel    (out_vel),
		.out_acc    (out_acc),
		.out_status (out_status)
	);

	assign m_tdata = {out_acc, out_vel, out_pos};
	assign m_tuser = out_status;

	// idle means the datapath has fully drained
	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !dp_stat.busy)
		else $error("input ready while datapath busy");

	// ops are issued only while a beat is in progress
	a_issue_busy: assert property (@(posedge clk) disable iff (!arst_n)
		uop.vld |-> !s_tready)
		else $error("op issued while idle");

	// a result is captured only after the pipeline is empty, and is then shown
	a_load_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!dp_stat.busy ##1 m_tvalid))
		else $error("result load out of order");

endmodule

[tb/sv/tb_kalman_filter_3state_scalar_meas.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_kalman_filter_3state_scalar_meas
// Self-checking bench for the three-state Kalman filter. A behavioral copy of
// the filter (Q8.24, saturating) predicts the state and status of every beat;
// directed tests cover loads, resets, predict/update and the innovation check,
// then random filter runs sweep several register settings under back-pressure.
// ----------------------------------------------------------------------------
module tb_kalman_filter_3state_scalar_meas;

	localparam logic [kf3_pkg::CFG_IDX_W-1:0] CFG_NONE = 3'd7;   // no register behind it
	localparam longint WMAX = 64'sd2147483647;
	localparam longint WMIN = -64'sd2147483648;

	typedef struct {
		kf3_pkg::word_t   pos;
		kf3_pkg::word_t   vel;
		kf3_pkg::word_t   acc;
		kf3_pkg::status_t st;
	} filt_out_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_wr_en;
	logic [kf3_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [kf3_pkg::WORD_W-1:0]    cfg_data;

	kalman_filter_3state_scalar_meas u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// filter shadow: registers and state
	longint t01, t02, t12, t22, r_noise, p_init;
	bit     ctrl_on;
	longint x_est[3], x_pred[3], p_est[9], p_pred[9], q_tab[6], b_col[3];
	bit     clip_hit;

	filt_out_t pending_states[$];
	int  mismatch_count;
	int  sink_gap, sink_hold;
	bit  sink_steady, src_steady;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 3_000_000);
		$display("kalman_filter_3state_scalar_meas verification failed");
		$finish;
	end

	// ---------------- fixed-point arithmetic of the filter ----------------
	function automatic longint sx32(input logic [31:0] v);
		return longint'($signed(v));
	endfunction

	function automatic longint clip(input longint v);
		if (v > WMAX) begin clip_hit = 1'b1; return WMAX; end
		if (v < WMIN) begin clip_hit = 1'b1; return WMIN; end
		return v;
	endfunction

	// product truncated toward zero by the fraction bits, then saturated
	function automatic longint fmul(input longint a, input longint b);
		longint p, m, lim;
		bit neg;
		p   = a * b;
		neg = (a < 0) != (b < 0);
		m   = (p < 0) ? -p : p;
		m   = m >>> kf3_pkg::FRAC_W;
		lim = neg ? WMAX + 1 : WMAX;
		if (m > lim) begin
			clip_hit = 1'b1;
			m = lim;
		end
		return neg ? -m : m;
	endfunction

	// fixed-point quotient n/d for d > 0, truncated and saturated
	function automatic longint fdiv(input longint n, input longint d);
		longint un, q, lim;
		bit neg;
		neg = n < 0;
		un  = neg ? -n : n;
		q   = (un <<< kf3_pkg::FRAC_W) / d;
		lim = neg ? WMAX + 1 : WMAX;
		if (q > lim) begin
			clip_hit = 1'b1;
			q = lim;
		end
		return neg ? -q : q;
	endfunction

	function automatic longint q_entry(input int i, input int j);
		int k;
		k = (i <= j) ? (i == 0 ? j : (i == 1 ? j + 2 : 5)) : (j == 0 ? i : (j == 1 ? i + 2 : 5));
		return q_tab[k];
	endfunction

	// one filter step: advance the shadow state, return the expected beat
	function automatic filt_out_t filter_step(input kf3_pkg::action_t act,
		input logic [31:0] z_raw, input logic [3:0] idx, input logic [31:0] cv_raw);
		longint a[3][3], m[3][3], g[3];
		longint acc, s, e;
		bit shown_pred, nonpos;
		filt_out_t r;
		clip_hit   = 1'b0;
		shown_pred = 1'b0;
		nonpos     = 1'b0;
		case (act)
			kf3_pkg::ACT_PREDICT: begin
				a = '{'{64'sd1 <<< kf3_pkg::FRAC_W, t01, t02},
					'{0, 64'sd1 <<< kf3_pkg::FRAC_W, t12}, '{0, 0, t22}};
				for (int i = 0; i < 3; i++) begin
					acc = fmul(a[i][0], x_est[0]);
					acc = clip(acc + fmul(a[i][1], x_est[1]));
					acc = clip(acc + fmul(a[i][2], x_est[2]));
					if (ctrl_on)
						acc = clip(acc + fmul(b_col[i], x_est[2]));
					x_pred[i] = acc;
				end
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++) begin
						acc = fmul(a[i][0], p_est[j]);
						for (int k = 1; k < 3; k++)
							acc = clip(acc + fmul(a[i][k], p_est[k*3+j]));
						m[i][j] = acc;
					end
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++) begin
						acc = fmul(m[i][0], a[j][0]);
						for (int k = 1; k < 3; k++)
							acc = clip(acc + fmul(m[i][k], a[j][k]));
						p_pred[i*3+j] = clip(acc + q_entry(i, j));
					end
				shown_pred = 1'b1;
			end
			kf3_pkg::ACT_UPDATE: begin
				s = clip(p_pred[0] + r_noise);
				if (s <= 0) begin
					nonpos = 1'b1;
				end else begin
					for (int i = 0; i < 3; i++)
						g[i] = fdiv(p_pred[i*3], s);
					e = clip(sx32(z_raw) - x_pred[0]);
					for (int i = 0; i < 3; i++)
						x_est[i] = clip(x_pred[i] + fmul(g[i], e));
					for (int i = 0; i < 3; i++)
						for (int j = 0; j < 3; j++)
							p_est[i*3+j] = clip(p_pred[i*3+j] - fmul(g[i], p_pred[j]));
				end
			end
			kf3_pkg::ACT_LOAD: begin
				if (idx < 6)
					q_tab[idx] = sx32(cv_raw);
				else if (idx < kf3_pkg::COEF_CNT)
					b_col[idx-6] = sx32(cv_raw);
			end
			default: begin
				for (int i = 0; i < 3; i++) x_est[i] = 0;
				for (int i = 0; i < 9; i++) p_est[i] = (i % 4 == 0) ? p_init : 0;
			end
		endcase
		r.pos = kf3_pkg::word_t'(shown_pred ? x_pred[0] : x_est[0]);
		r.vel = kf3_pkg::word_t'(shown_pred ? x_pred[1] : x_est[1]);
		r.acc = kf3_pkg::word_t'(shown_pred ? x_pred[2] : x_est[2]);
		r.st  = nonpos ? kf3_pkg::ST_INV_VAR : (clip_hit ? kf3_pkg::ST_SAT : kf3_pkg::ST_OK);
		return r;
	endfunction

	// ---------------- result side ----------------
	initial begin
		m_tready = 1'b0;
		sink_gap = 0;
		sink_hold = 0;
		sink_steady = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				m_tready <= 1'b0;
				sink_hold--;
			end else if (sink_gap > 0) begin
				m_tready <= 1'b0;
				sink_gap--;
			end else begin
				m_tready <= arst_n;
			end
		end
	end

	// check every accepted result beat against the oldest expectation
	always @(posedge clk) begin
		filt_out_t x;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_states.size() == 0) begin
				$display("%0t: unexpected result beat %h status %0d", $time, m_tdata, m_tuser);
				mismatch_count++;
			end else begin
				x = pending_states.pop_front();
				if (m_tdata[31:0] !== x.pos) begin
					$display("%0t: pos exp %h act %h", $time, x.pos, m_tdata[31:0]);
					mismatch_count++;
				end
				if (m_tdata[63:32] !== x.vel) begin
					$display("%0t: vel exp %h act %h", $time, x.vel, m_tdata[63:32]);
					mismatch_count++;
				end
				if (m_tdata[95:64] !== x.acc) begin
					$display("%0t: acc exp %h act %h", $time, x.acc, m_tdata[95:64]);
					mismatch_count++;
				end
				if (m_tuser !== x.st) begin
					$display("%0t: status exp %0d act %0d", $time, x.st, m_tuser);
					mismatch_count++;
				end
			end
			sink_gap = sink_steady ? 0 : $urandom_range(0, 3);
		end
	end

	// ---------------- stimulus helpers ----------------
	// offer one beat after a random gap; predict its result once accepted
	task automatic send_beat(input kf3_pkg::action_t act, input logic [31:0] z,
		input logic [3:0] idx, input logic [31:0] cv);
		int gap;
		gap = src_steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {4'b0, cv, idx, z};
		do @(posedge clk); while (!s_tready);
		pending_states.push_back(filter_step(act, z, idx, cv));
	endtask

	// hold input until every expected beat is back
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_states.size() > 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic [kf3_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] v);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			kf3_pkg::CFG_T01:  t01 = sx32(v);
			kf3_pkg::CFG_T02:  t02 = sx32(v);
			kf3_pkg::CFG_T12:  t12 = sx32(v);
			kf3_pkg::CFG_T22:  t22 = sx32(v);
			kf3_pkg::CFG_R:    r_noise = longint'(v & 32'h7FFF_FFFF);
			kf3_pkg::CFG_INIT: p_init = longint'(v & 32'h7FFF_FFFF);
			kf3_pkg::CFG_CEN:  ctrl_on = v[0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [31:0] a01, input logic [31:0] a02,
		input logic [31:0] a12, input logic [31:0] a22, input logic [31:0] rn,
		input logic [31:0] pi, input logic [31:0] ce);
		write_reg(kf3_pkg::CFG_T01, a01);
		write_reg(kf3_pkg::CFG_T02, a02);
		write_reg(kf3_pkg::CFG_T12, a12);
		write_reg(kf3_pkg::CFG_T22, a22);
		write_reg(kf3_pkg::CFG_R, rn);
		write_reg(kf3_pkg::CFG_INIT, pi);
		write_reg(kf3_pkg::CFG_CEN, ce);
	endtask

	function automatic logic [31:0] small_val();
		return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
	endfunction

	// ---------------- tests ----------------
	// update straight after reset, then fill Q and b, including unused indexes
	task automatic test_loads();
		send_beat(kf3_pkg::ACT_UPDATE, 32'h0100_0000, 4'd0, 32'h0);
		send_beat(kf3_pkg::ACT_RESET, 32'h0, 4'd0, 32'h0);
		for (int i = 0; i < 9; i++)
			send_beat(kf3_pkg::ACT_LOAD, 32'hFFFF_FFFF, 4'(i),
				(i < 6) ? 32'h0004_0000 : 32'h0020_0000);
		send_beat(kf3_pkg::ACT_LOAD, 32'h0, 4'd9, 32'hDEAD_BEEF);
		send_beat(kf3_pkg::ACT_LOAD, 32'h0, 4'd15, 32'h1234_5678);
	endtask

	task automatic test_track();
		for (int i = 0; i < 4; i++) begin
			send_beat(kf3_pkg::ACT_PREDICT, 32'h0, 4'd0, 32'h0);
			send_beat(kf3_pkg::ACT_UPDATE, 32'(i * 32'h0180_0000), 4'd0, 32'h0);
		end
	endtask

	// zero R and zero covariance make the innovation variance zero
	task automatic test_nonpos_innovation();
		drain();
		write_reg(kf3_pkg::CFG_R, 32'h0);
		write_reg(kf3_pkg::CFG_INIT, 32'h0);
		send_beat(kf3_pkg::ACT_RESET, 32'h0, 4'd0, 32'h0);
		send_beat(kf3_pkg::ACT_LOAD, 32'h0, 4'd0, 32'h0);
		send_beat(kf3_pkg::ACT_PREDICT, 32'h0, 4'd0, 32'h0);
		send_beat(kf3_pkg::ACT_UPDATE, 32'h0500_0000, 4'd0, 32'h0);
		send_beat(kf3_pkg::ACT_LOAD, 32'h0, 4'd0, 32'h8000_0000);
		send_beat(kf3_pkg::ACT_PREDICT, 32'h0, 4'd0, 32'h0);
		send_beat(kf3_pkg::ACT_UPDATE, 32'h0500_0000, 4'd0, 32'h0);
		drain();
		write_reg(kf3_pkg::CFG_R, 32'h0002_8F5C);
		write_reg(kf3_pkg::CFG_INIT, 32'h0002_8F5C);
	endtask

	// full-scale measurements and coefficients drive saturation
	task automatic test_extremes();
		send_beat(kf3_pkg::ACT_RESET, 32'h0, 4'd0, 32'h0);
		send_beat(kf3_pkg::ACT_LOAD, 32'h0, 4'd0, 32'h7FFF_FFFF);
		send_beat(kf3_pkg::ACT_PREDICT, 32'h0, 4'd0, 32'h0);
		send_beat(kf3_pkg::ACT_UPDATE, 32'h7FFF_FFFF, 4'd0, 32'h0);
		send_beat(kf3_pkg::ACT_PREDICT, 32'h0, 4'd0, 32'h0);
		send_beat(kf3_pkg::ACT_UPDATE, 32'h8000_0000, 4'd0, 32'h0);
		send_beat(kf3_pkg::ACT_LOAD, 32'h0, 4'd0, 32'h0004_0000);
		send_beat(kf3_pkg::ACT_RESET, 32'h0, 4'd0, 32'h0);
	endtask

	// receiver holds off long while beats keep coming, then the sender waits
	task automatic test_backpressure();
		sink_hold = 600;
		src_steady = 1'b1;
		for (int i = 0; i < 4; i++) begin
			send_beat(kf3_pkg::ACT_PREDICT, 32'h0, 4'd0, 32'h0);
			send_beat(kf3_pkg::ACT_UPDATE, small_val(), 4'd0, 32'h0);
		end
		src_steady = 1'b0;
		drain();
	endtask

	// random filter runs: mostly well-formed sequences, some noise beats
	task automatic test_random_runs(input int n_items);
		int sent;
		logic [31:0] z;
		sent = 0;
		while (sent < n_items) begin
			src_steady  = ($urandom_range(0, 7) == 0);
			sink_steady = ($urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) == 0) begin
				send_beat(kf3_pkg::action_t'($urandom_range(0, 3)), $urandom, 4'($urandom),
					$urandom);
				sent++;
				continue;
			end
			if ($urandom_range(0, 3) == 0) begin
				send_beat(kf3_pkg::ACT_RESET, $urandom, 4'($urandom), $urandom);
				sent++;
			end
			repeat ($urandom_range(0, 2)) begin
				send_beat(kf3_pkg::ACT_LOAD, $urandom, 4'($urandom_range(0, 9)),
					($urandom_range(0, 7) == 0) ? $urandom : small_val() >>> 4);
				sent++;
			end
			z = small_val();
			repeat ($urandom_range(1, 6)) begin
				z = z + (small_val() >>> 3);
				send_beat(kf3_pkg::ACT_PREDICT, $urandom, 4'($urandom), $urandom);
				send_beat(kf3_pkg::ACT_UPDATE, ($urandom_range(0, 15) == 0) ? $urandom : z,
					4'($urandom), $urandom);
				sent += 2;
			end
		end
		src_steady  = 1'b0;
		sink_steady = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = kf3_pkg::ACT_PREDICT;
		cfg_wr_en = 1'b0;
		cfg_index = kf3_pkg::CFG_T01;
		cfg_data  = '0;
		mismatch_count = 0;
		src_steady = 1'b0;
		t01 = 16777216; t02 = 8388608; t12 = 16777216; t22 = 16777216;
		r_noise = 167772; p_init = 167772; ctrl_on = 1'b0;
		for (int i = 0; i < 3; i++) begin x_est[i] = 0; x_pred[i] = 0; b_col[i] = 0; end
		for (int i = 0; i < 9; i++) begin p_est[i] = 0; p_pred[i] = 0; end
		for (int i = 0; i < 6; i++) q_tab[i] = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_loads();
		test_track();
		test_nonpos_innovation();
		test_extremes();
		test_backpressure();

		// default registers
		test_random_runs(150);
		drain();
		// moderate random setting with control term; unknown index ignored
		write_all(32'($urandom_range(0, 1 << 25)), 32'($urandom_range(0, 1 << 24)),
			32'($urandom_range(0, 1 << 25)), 32'($urandom_range(1 << 23, 1 << 24)),
			$urandom, $urandom, 32'h1);
		write_reg(CFG_NONE, 32'hFFFF_FFFF);
		test_random_runs(170);
		drain();
		// extremes: full-scale transition, largest R and covariance
		write_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
			32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h1);
		test_random_runs(120);
		drain();
		// zero transition terms, zero R and covariance
		write_all(32'h0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 32'h0, 32'h0);
		test_random_runs(120);
		drain();
		write_all(32'h0100_0000, 32'h0080_0000, 32'h0100_0000, 32'h0100_0000,
			32'h0002_8F5C, 32'h0002_8F5C, 32'h0);
		test_random_runs(60);

		drain();
		repeat (300) @(posedge clk);
		if (mismatch_count == 0)
			$display("kalman_filter_3state_scalar_meas verification clean");
		else
			$display("kalman_filter_3state_scalar_meas verification failed");
		$finish;
	end

endmodule
